/* design/sct_list_parser_top_macros.svh */
// Assertion macros shared by the timestamp list parser modules.
`ifndef SCT_LIST_PARSER_TOP_MACROS_SVH
`define SCT_LIST_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SCTLP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SCTLP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sctlp_pkg.sv */
// Types, constants and helper functions of the timestamp list parser.
`default_nettype none

package sctlp_pkg;

    localparam int LOG_ID_BYTES = 32;
    localparam int HDR_BYTES = 11 + LOG_ID_BYTES;
    localparam int SIG_HDR_BYTES = 4;
    localparam int TIME_BYTES = 8;
    localparam logic [16:0] CNT_MAX = 17'h1FFFF;
    localparam logic [15:0] MAX_LIST_RESET = 16'hFFFF;

    // Register index of max_list_bytes on the configuration port.
    localparam logic REG_MAX_LIST = 1'b0;

    typedef enum logic [3:0] {
        PH_LHI   = 4'd0,
        PH_LLO   = 4'd1,
        PH_EHI   = 4'd2,
        PH_ELO   = 4'd3,
        PH_VER   = 4'd4,
        PH_LOGID = 4'd5,
        PH_TIME  = 4'd6,
        PH_XHI   = 4'd7,
        PH_XLO   = 4'd8,
        PH_XDAT  = 4'd9,
        PH_HASH  = 4'd10,
        PH_SALG  = 4'd11,
        PH_SHI   = 4'd12,
        PH_SLO   = 4'd13,
        PH_SDAT  = 4'd14,
        PH_SKIP  = 4'd15
    } phase_t;

    localparam logic [3:0] KIND_LIST_LEN  = 4'd0;
    localparam logic [3:0] KIND_ENTRY_LEN = 4'd1;
    localparam logic [3:0] KIND_VERSION   = 4'd2;
    localparam logic [3:0] KIND_LOG_ID    = 4'd3;
    localparam logic [3:0] KIND_TIME      = 4'd4;
    localparam logic [3:0] KIND_EXT_LEN   = 4'd5;
    localparam logic [3:0] KIND_EXT       = 4'd6;
    localparam logic [3:0] KIND_HASH      = 4'd7;
    localparam logic [3:0] KIND_SIG_ALG   = 4'd8;
    localparam logic [3:0] KIND_SIG_LEN   = 4'd9;
    localparam logic [3:0] KIND_SIG       = 4'd10;
    localparam logic [3:0] KIND_SKIPPED   = 4'd11;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_SIZE       = 4'd1;
    localparam logic [3:0] ERR_LIST_LEN   = 4'd2;
    localparam logic [3:0] ERR_ENTRY_LEN  = 4'd3;
    localparam logic [3:0] ERR_VERSION    = 4'd4;
    localparam logic [3:0] ERR_SHORT_HDR  = 4'd5;
    localparam logic [3:0] ERR_EXT_LEN    = 4'd6;
    localparam logic [3:0] ERR_SIG_HDR    = 4'd7;
    localparam logic [3:0] ERR_SIG_LEN    = 4'd8;

    // One result beat.
    typedef struct packed {
        logic [3:0]  field_kind;
        logic [7:0]  byte_value;
        logic        field_done;
        logic [63:0] field_value;
        logic        entry_done;
        logic [15:0] entry_index;
        logic        list_done;
        logic [3:0]  status;
    } res_t;

    // A buffer size error beats everything, a list length error beats entry
    // errors, and otherwise the first error stays.
    function automatic logic [3:0] merge_err(input logic [3:0] cur, input logic [3:0] e);
        logic [3:0] r;
        r = cur;
        if (cur == ERR_NONE || e == ERR_SIZE || (e == ERR_LIST_LEN && cur != ERR_SIZE)) begin
            r = e;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/sctlp_parse.sv */
// Parse state registers and the per-byte next-state and tagging logic.
`default_nettype none

module sctlp_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic [15:0]       max_list,
    output sctlp_pkg::res_t        res
);

`include "sct_list_parser_top_macros.svh"

    sctlp_pkg::phase_t phase_reg, phase_next;
    logic [15:0] lr_reg, lr_next;
    logic [15:0] er_reg, er_next;
    logic [15:0] fbl_reg, fbl_next;
    logic [63:0] acc_reg, acc_next;
    logic [16:0] cnt_reg, cnt_next;
    logic [15:0] ec_reg, ec_next;
    logic [3:0]  err_reg, err_next;

    logic [3:0]  kind;
    logic        done;
    logic        edone;
    logic [63:0] val;
    logic [15:0] v16;
    logic [15:0] fbl_dec;

    always_comb begin
        phase_next = phase_reg;
        lr_next    = lr_reg;
        er_next    = er_reg;
        fbl_next   = fbl_reg;
        acc_next   = acc_reg;
        ec_next    = ec_reg;
        err_next   = err_reg;
        kind       = sctlp_pkg::KIND_SKIPPED;
        done       = 1'b0;
        edone      = 1'b0;
        val        = '0;
        v16        = {acc_reg[7:0], in_byte};
        fbl_dec    = (fbl_reg != 16'd0) ? fbl_reg - 16'd1 : 16'd0;

        cnt_next = (cnt_reg != sctlp_pkg::CNT_MAX) ? cnt_reg + 17'd1 : cnt_reg;
        if (cnt_next > {1'b0, max_list}) begin
            err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_SIZE);
            phase_next = sctlp_pkg::PH_SKIP;
        end

        // Every byte after the list length header is owed by the list.
        if (phase_next >= sctlp_pkg::PH_EHI) begin
            if (lr_next == 16'd0) begin
                err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_LIST_LEN);
                phase_next = sctlp_pkg::PH_SKIP;
            end else begin
                lr_next = lr_next - 16'd1;
            end
        end
        if (phase_next >= sctlp_pkg::PH_VER && phase_next <= sctlp_pkg::PH_SDAT &&
            er_next != 16'd0) begin
            er_next = er_next - 16'd1;
        end

        unique case (phase_next)
            sctlp_pkg::PH_LHI: begin
                kind       = sctlp_pkg::KIND_LIST_LEN;
                acc_next   = {56'd0, in_byte};
                phase_next = sctlp_pkg::PH_LLO;
            end
            sctlp_pkg::PH_LLO: begin
                kind       = sctlp_pkg::KIND_LIST_LEN;
                done       = 1'b1;
                val        = {48'd0, v16};
                acc_next   = '0;
                lr_next    = v16;
                phase_next = (v16 != 16'd0) ? sctlp_pkg::PH_EHI : sctlp_pkg::PH_SKIP;
            end
            sctlp_pkg::PH_EHI: begin
                kind = sctlp_pkg::KIND_ENTRY_LEN;
                if (lr_next == 16'd0) begin
                    err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_ENTRY_LEN);
                    phase_next = sctlp_pkg::PH_SKIP;
                end else begin
                    acc_next   = {56'd0, in_byte};
                    phase_next = sctlp_pkg::PH_ELO;
                end
            end
            sctlp_pkg::PH_ELO: begin
                kind     = sctlp_pkg::KIND_ENTRY_LEN;
                done     = 1'b1;
                val      = {48'd0, v16};
                acc_next = '0;
                if (v16 == 16'd0 || v16 > lr_next) begin
                    err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_ENTRY_LEN);
                    phase_next = sctlp_pkg::PH_SKIP;
                end else begin
                    er_next    = v16;
                    phase_next = sctlp_pkg::PH_VER;
                end
            end
            sctlp_pkg::PH_VER: begin
                kind = sctlp_pkg::KIND_VERSION;
                done = 1'b1;
                val  = {56'd0, in_byte};
                if (in_byte != 8'd0) begin
                    err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_VERSION);
                    phase_next = sctlp_pkg::PH_SKIP;
                end else if (({1'b0, er_next} + 17'd1) < 17'(sctlp_pkg::HDR_BYTES)) begin
                    err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_SHORT_HDR);
                    phase_next = sctlp_pkg::PH_SKIP;
                end else begin
                    fbl_next   = 16'(sctlp_pkg::LOG_ID_BYTES);
                    phase_next = sctlp_pkg::PH_LOGID;
                end
            end
            sctlp_pkg::PH_LOGID, sctlp_pkg::PH_TIME: begin
                kind     = (phase_next == sctlp_pkg::PH_LOGID) ? sctlp_pkg::KIND_LOG_ID
                                                               : sctlp_pkg::KIND_TIME;
                acc_next = {acc_reg[55:0], in_byte};
                fbl_next = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    done     = 1'b1;
                    val      = acc_next;
                    acc_next = '0;
                    if (phase_next == sctlp_pkg::PH_LOGID) begin
                        fbl_next   = 16'(sctlp_pkg::TIME_BYTES);
                        phase_next = sctlp_pkg::PH_TIME;
                    end else begin
                        phase_next = sctlp_pkg::PH_XHI;
                    end
                end
            end
            sctlp_pkg::PH_XHI: begin
                kind       = sctlp_pkg::KIND_EXT_LEN;
                acc_next   = {56'd0, in_byte};
                phase_next = sctlp_pkg::PH_XLO;
            end
            sctlp_pkg::PH_XLO: begin
                kind     = sctlp_pkg::KIND_EXT_LEN;
                done     = 1'b1;
                val      = {48'd0, v16};
                acc_next = '0;
                if (v16 > er_next) begin
                    err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_EXT_LEN);
                    phase_next = sctlp_pkg::PH_SKIP;
                end else if (v16 == 16'd0) begin
                    if (er_next < 16'(sctlp_pkg::SIG_HDR_BYTES)) begin
                        err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_SIG_HDR);
                        phase_next = sctlp_pkg::PH_SKIP;
                    end else begin
                        phase_next = sctlp_pkg::PH_HASH;
                    end
                end else begin
                    fbl_next   = v16;
                    phase_next = sctlp_pkg::PH_XDAT;
                end
            end
            sctlp_pkg::PH_XDAT, sctlp_pkg::PH_SDAT: begin
                kind     = (phase_next == sctlp_pkg::PH_XDAT) ? sctlp_pkg::KIND_EXT
                                                              : sctlp_pkg::KIND_SIG;
                acc_next = {acc_reg[55:0], in_byte};
                fbl_next = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    done     = 1'b1;
                    val      = acc_next;
                    acc_next = '0;
                    if (phase_next == sctlp_pkg::PH_XDAT) begin
                        if (er_next < 16'(sctlp_pkg::SIG_HDR_BYTES)) begin
                            err_next   = sctlp_pkg::merge_err(err_next,
                                                              sctlp_pkg::ERR_SIG_HDR);
                            phase_next = sctlp_pkg::PH_SKIP;
                        end else begin
                            phase_next = sctlp_pkg::PH_HASH;
                        end
                    end else begin
                        edone      = 1'b1;
                        ec_next    = ec_reg + 16'd1;
                        phase_next = (lr_next != 16'd0) ? sctlp_pkg::PH_EHI
                                                        : sctlp_pkg::PH_SKIP;
                    end
                end
            end
            sctlp_pkg::PH_HASH: begin
                kind       = sctlp_pkg::KIND_HASH;
                done       = 1'b1;
                val        = {56'd0, in_byte};
                phase_next = sctlp_pkg::PH_SALG;
            end
            sctlp_pkg::PH_SALG: begin
                kind       = sctlp_pkg::KIND_SIG_ALG;
                done       = 1'b1;
                val        = {56'd0, in_byte};
                phase_next = sctlp_pkg::PH_SHI;
            end
            sctlp_pkg::PH_SHI: begin
                kind       = sctlp_pkg::KIND_SIG_LEN;
                acc_next   = {56'd0, in_byte};
                phase_next = sctlp_pkg::PH_SLO;
            end
            sctlp_pkg::PH_SLO: begin
                kind     = sctlp_pkg::KIND_SIG_LEN;
                done     = 1'b1;
                val      = {48'd0, v16};
                acc_next = '0;
                if (v16 != er_next) begin
                    err_next   = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_SIG_LEN);
                    phase_next = sctlp_pkg::PH_SKIP;
                end else if (v16 == 16'd0) begin
                    edone      = 1'b1;
                    ec_next    = ec_reg + 16'd1;
                    phase_next = (lr_next != 16'd0) ? sctlp_pkg::PH_EHI
                                                    : sctlp_pkg::PH_SKIP;
                end else begin
                    fbl_next   = v16;
                    phase_next = sctlp_pkg::PH_SDAT;
                end
            end
            sctlp_pkg::PH_SKIP: begin
                kind = sctlp_pkg::KIND_SKIPPED;
            end
        endcase

        // The last byte settles the final status.
        if (in_last) begin
            if (cnt_next < 17'd2) begin
                err_next = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_SIZE);
            end else if (lr_next != 16'd0) begin
                err_next = sctlp_pkg::merge_err(err_next, sctlp_pkg::ERR_LIST_LEN);
            end
        end
    end

    always_comb begin
        res.field_kind  = kind;
        res.byte_value  = in_byte;
        res.field_done  = done;
        res.field_value = done ? val : 64'd0;
        res.entry_done  = edone;
        res.entry_index = ec_reg;
        res.list_done   = in_last;
        res.status      = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && in_last)) begin
            phase_reg <= sctlp_pkg::PH_LHI;
            lr_reg    <= '0;
            er_reg    <= '0;
            fbl_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            ec_reg    <= '0;
            err_reg   <= sctlp_pkg::ERR_NONE;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            lr_reg    <= lr_next;
            er_reg    <= er_next;
            fbl_reg   <= fbl_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            ec_reg    <= ec_next;
            err_reg   <= err_next;
        end
    end

    `SCTLP_ASSERT_IMP(a_err_skips, aclk, aresetn,
        err_reg != sctlp_pkg::ERR_NONE, phase_reg == sctlp_pkg::PH_SKIP,
        "error recorded while the parser is not skipping")
    `SCTLP_ASSERT_NXT(a_last_clears, aclk, aresetn,
        in_accept && in_last,
        phase_reg == sctlp_pkg::PH_LHI && cnt_reg == 17'd0 && err_reg == sctlp_pkg::ERR_NONE,
        "parse state not cleared after the last byte")
    `SCTLP_ASSERT_IMP(a_entry_has_field, aclk, aresetn,
        in_accept && res.entry_done, res.field_done,
        "entry ended without a completed field")

endmodule

`default_nettype wire

/* design/sctlp_skid.sv */
// Result register with a skid stage between the parser and the output channel.
`default_nettype none

module sctlp_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sctlp_pkg::res_t   in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sctlp_pkg::res_t        out_data
);

`include "sct_list_parser_top_macros.svh"

    logic            out_valid_reg, out_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    sctlp_pkg::res_t out_data_reg, out_data_next;
    sctlp_pkg::res_t skid_data_reg, skid_data_next;
    logic            push;
    logic            pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `SCTLP_ASSERT_IMP(a_skid_behind_out, aclk, aresetn,
        skid_valid_reg, out_valid_reg,
        "skid stage holds a beat while the result register is empty")
    `SCTLP_ASSERT_NXT(a_skid_holds, aclk, aresetn,
        skid_valid_reg && !out_ready, skid_valid_reg && $stable(skid_data_reg),
        "skid beat lost while the output is stalled")
    `SCTLP_ASSERT_NXT(a_out_holds, aclk, aresetn,
        out_valid_reg && !out_ready, out_valid_reg && $stable(out_data_reg),
        "result beat changed while the output is stalled")

endmodule

`default_nettype wire

/* design/sct_list_parser_top.sv */
// Top level of the timestamp list parser: configuration register and channels.
// A result beat is registered in the result register, or in the skid stage if stalled.
// Throughput: one beat per cycle while s_tready is high; the parse logic between state
// and result registers is combinational, and a two-entry result stage takes up
// output stalls. s_tready falls only while both result entries are full.
// Synchronous reset clears parse state and result stage and sets max_list_bytes to 65535.
`default_nettype none

module sct_list_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel. s_tdata: [7:0] data_byte. s_tlast: last_byte.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // Result channel.
    // m_tdata: [7:0] byte_value, [8] field_done, [72:9] field_value, [73] entry_done,
    //          [89:74] entry_index, [93:90] status, [95:94] zero.
    // m_tuser: [3:0] field_kind. m_tlast: list_done.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,
    output logic [3:0]       m_tuser,
    output logic             m_tlast,
    // Configuration port. Register 0 (byte address 0): max_list_bytes.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0]     max_list_reg;
    logic            in_accept;
    sctlp_pkg::res_t parse_res;
    sctlp_pkg::res_t out_res;

    // The register takes its value at the access phase of a write. Only the low
    // 16 bits of the data are kept.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_list_reg <= sctlp_pkg::MAX_LIST_RESET;
        end else if (psel && penable && pwrite && paddr[2] == sctlp_pkg::REG_MAX_LIST) begin
            max_list_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == sctlp_pkg::REG_MAX_LIST) ? {16'd0, max_list_reg} : 32'd0;

    // A byte is taken whenever the result stage has room for its beat.
    assign in_accept = s_tvalid && s_tready;

    sctlp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .max_list  (max_list_reg),
        .res       (parse_res)
    );

    sctlp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result beat onto the stream ports.
    assign m_tdata = {2'b00, out_res.status, out_res.entry_index, out_res.entry_done,
                      out_res.field_value, out_res.field_done, out_res.byte_value};
    assign m_tuser = out_res.field_kind;
    assign m_tlast = out_res.list_done;

endmodule

`default_nettype wire
